### hw/rtl/grc_pkg.sv
// Package with the shared types and constants of the grid raycast column block.
package grc_pkg;

	localparam int MAP_SIZE_D = 32;
	localparam int SCREEN_WIDTH_D = 1024;
	localparam int SCREEN_HEIGHT_D = 1024;
	localparam int MAX_STEPS_D = 64;
	localparam int ONE_CELL = 2048;

	localparam logic [2:0] REG_POS_X = 3'd0;
	localparam logic [2:0] REG_POS_Y = 3'd1;
	localparam logic [2:0] REG_DIR_X = 3'd2;
	localparam logic [2:0] REG_DIR_Y = 3'd3;
	localparam logic [2:0] REG_PLANE_X = 3'd4;
	localparam logic [2:0] REG_PLANE_Y = 3'd5;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_CAST = 1'b1;

	localparam logic [3:0] CODE_RED = 4'd1;
	localparam logic [3:0] CODE_WHITE = 4'd2;
	localparam logic [3:0] CODE_BLUE = 4'd3;
	localparam logic [3:0] CODE_WHITE2 = 4'd4;
	localparam logic [3:0] CODE_FACE = 4'd8;
	localparam logic [3:0] CODE_BLACK = 4'd9;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RAYX,
		ST_RAYY,
		ST_CMP,
		ST_STEP,
		ST_READ,
		ST_CHECK,
		ST_DIV,
		ST_SPAN,
		ST_OUT
	} state_t;

	function automatic logic [23:0] code_color(input logic [3:0] code);
		logic [23:0] c;
		unique case (code)
			CODE_RED: c = 24'hFF0000;
			CODE_WHITE: c = 24'hFFFFFF;
			CODE_BLUE: c = 24'h0045FF;
			CODE_WHITE2: c = 24'hFFFFFF;
			CODE_BLACK: c = 24'h000000;
			default: c = 24'h00FFFF;
		endcase
		return c;
	endfunction

endpackage

### hw/rtl/grc_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module grc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### hw/rtl/grc_div.sv
// Restoring divider that produces one quotient bit per cycle.
module grc_div #(
	parameter int NW = 32,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW+1:0] diff;

	assign trial = {rem_q[DW-1:0], quo_q[NW-1]};
	assign diff = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DW+1]) begin
				rem_q <= diff[DW:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo = quo_q;
endmodule

### hw/rtl/grid_raycast_column.sv
// Top level of the grid raycast column block: registers, sequencer and datapath.
//
// Channel | Direction | Handshake       | Payload
// in      | input     | in_valid/stall  | func, cell_row, cell_col, cell_value, column
// out     | output    | out_valid/stall | column_out, draw_start, draw_end, wall_color,
//         |           |                 | hit_side, no_hit
// cfg     | input     | APB             | pos, dir and plane registers
//
// A map write is done in the idle state. A cast forms the ray, runs DDA steps (compare, step,
// map read, check), runs the divider on a hit, and then forms and loads the result.
// The step loop sets the time of a long cast.
// Reset clears the control state and the registers; the map stays undefined until written.
// A finished result waits in the output register while the next item is taken; a second
// result is held back until the first one is transferred.
module grid_raycast_column
	import grc_pkg::*;
#(
	parameter int MAP_SIZE = grc_pkg::MAP_SIZE_D,
	parameter int SCREEN_WIDTH = grc_pkg::SCREEN_WIDTH_D,
	parameter int SCREEN_HEIGHT = grc_pkg::SCREEN_HEIGHT_D,
	parameter int MAX_STEPS = grc_pkg::MAX_STEPS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [4:0]  cell_row,
	input  logic [4:0]  cell_col,
	input  logic [3:0]  cell_value,
	input  logic [9:0]  column,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [9:0]  column_out,
	output logic [9:0]  draw_start,
	output logic [9:0]  draw_end,
	output logic [23:0] wall_color,
	output logic        hit_side,
	output logic        no_hit
);
	localparam int MW = $clog2(MAP_SIZE);
	localparam int AW = 2 * MW;
	localparam int SW = $clog2(MAX_STEPS + 1);
	localparam int HW = $clog2(2 * SCREEN_HEIGHT + 1);
	localparam int CW = 28;
	localparam int NW = 32;

	logic [15:0] pos_x_q, pos_y_q, dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	state_t state_q, state_d;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= 16'd0;
			pos_y_q <= 16'd0;
			dir_x_q <= 16'd16384;
			dir_y_q <= 16'd0;
			plane_x_q <= 16'd0;
			plane_y_q <= 16'd10813;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				REG_POS_X: pos_x_q <= pwdata[15:0];
				REG_POS_Y: pos_y_q <= pwdata[15:0];
				REG_DIR_X: dir_x_q <= pwdata[15:0];
				REG_DIR_Y: dir_y_q <= pwdata[15:0];
				REG_PLANE_X: plane_x_q <= pwdata[15:0];
				REG_PLANE_Y: plane_y_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_POS_X: prdata = {16'd0, pos_x_q};
			REG_POS_Y: prdata = {16'd0, pos_y_q};
			REG_DIR_X: prdata = {16'd0, dir_x_q};
			REG_DIR_Y: prdata = {16'd0, dir_y_q};
			REG_PLANE_X: prdata = {16'd0, plane_x_q};
			REG_PLANE_Y: prdata = {16'd0, plane_y_q};
			default: prdata = 32'd0;
		endcase
	end

	// Cast datapath registers.
	logic [9:0]  col_q;
	logic signed [15:0] cam_q;
	logic signed [18:0] rx_q;
	logic [17:0] ax_q, ay_q;
	logic        sx_q, sy_q;
	logic [MW+1:0] mx_q, my_q;
	logic [CW-1:0] tx_q, ty_q, crossed_q;
	logic        side_q;
	logic [SW-1:0] steps_q;
	logic [3:0]  code_q;
	logic        hit_q;
	logic [HW-1:0] h_q;

	// Shared multiplier: ray products in the ray states, DDA cross products in compare and step.
	logic signed [28:0] mul_a;
	logic signed [18:0] mul_b;
	logic signed [47:0] mul_p;
	assign mul_p = mul_a * mul_b;
	logic [47:0] pa_q;

	always_comb begin
		mul_a = 29'sd0;
		mul_b = 19'sd0;
		unique case (state_q)
			ST_RAYX: begin
				mul_a = 29'(signed'(plane_x_q));
				mul_b = 19'(cam_q);
			end
			ST_RAYY: begin
				mul_a = 29'(signed'(plane_y_q));
				mul_b = 19'(cam_q);
			end
			ST_CMP: begin
				mul_a = signed'({1'b0, tx_q});
				mul_b = signed'({1'b0, ay_q});
			end
			ST_STEP: begin
				mul_a = signed'({1'b0, ty_q});
				mul_b = signed'({1'b0, ax_q});
			end
			default: ;
		endcase
	end

	logic signed [18:0] rnext;
	assign rnext = 19'(signed'(mul_p >>> 14));

	logic signed [18:0] ry_w;
	assign ry_w = 19'(signed'(dir_y_q)) + rnext;

	// Map store.
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [3:0]    ram_rdata;
	logic          wr_ok;
	logic [7:0]    wr_row, wr_col;
	assign wr_row = {3'd0, cell_row};
	assign wr_col = {3'd0, cell_col};
	assign wr_ok = (wr_row < 8'(MAP_SIZE)) && (wr_col < 8'(MAP_SIZE));
	assign ram_we = (state_q == ST_IDLE) && in_valid && (func == FUNC_WRITE) && wr_ok;
	assign ram_waddr = {cell_row[MW-1:0], cell_col[MW-1:0]};
	assign ram_raddr = {mx_q[MW-1:0], my_q[MW-1:0]};

	grc_ram #(.WIDTH(4), .DEPTH(MAP_SIZE * MAP_SIZE)) u_map (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(cell_value),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// Divider for the line height.
	logic          div_start, div_done;
	logic [NW-1:0] div_num, div_quo;
	logic [CW+2:0] div_den;
	assign div_start = (state_q == ST_CHECK) && (ram_rdata != 4'd0);
	assign div_num = NW'(SCREEN_HEIGHT) * NW'(side_q ? ay_q : ax_q);
	assign div_den = {crossed_q, 3'b000};

	grc_div #(.NW(NW), .DW(CW + 3)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	logic out_take;
	logic out_load;
	assign out_take = out_valid && !out_stall;
	assign out_load = (state_q == ST_OUT) && (!out_valid || out_take);
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	logic out_map;
	assign out_map = (mx_q >= (MW + 2)'(MAP_SIZE)) || (my_q >= (MW + 2)'(MAP_SIZE));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid && func == FUNC_CAST) state_d = ST_RAYX;
			ST_RAYX: state_d = ST_RAYY;
			ST_RAYY: state_d = ST_CMP;
			ST_CMP: state_d = ST_STEP;
			ST_STEP: state_d = ST_READ;
			ST_READ: state_d = out_map ? ST_SPAN : ST_CHECK;
			ST_CHECK: begin
				if (ram_rdata != 4'd0) state_d = ST_DIV;
				else if (steps_q == SW'(MAX_STEPS)) state_d = ST_SPAN;
				else state_d = ST_CMP;
			end
			ST_DIV: if (div_done) state_d = ST_SPAN;
			ST_SPAN: state_d = ST_OUT;
			ST_OUT: if (!out_valid || out_take) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	logic [47:0] pb;
	assign pb = mul_p;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				col_q <= column;
				cam_q <= 16'(signed'({1'b0, 26'(32'(column) * 32'd32768 / 32'(SCREEN_WIDTH))}))
					- 16'sd16384;
				mx_q <= (MW + 2)'(pos_x_q[15:11]);
				my_q <= (MW + 2)'(pos_y_q[15:11]);
				steps_q <= '0;
				hit_q <= 1'b0;
			end
			ST_RAYX: begin
				rx_q <= 19'(signed'(dir_x_q)) + rnext;
			end
			ST_RAYY: begin
				ax_q <= rx_q[18] ? 18'(-rx_q) : 18'(rx_q);
				ay_q <= ry_w[18] ? 18'(-ry_w) : 18'(ry_w);
				sx_q <= rx_q[18];
				sy_q <= ry_w[18];
				tx_q <= rx_q[18] ? CW'(pos_x_q[10:0]) : CW'(ONE_CELL) - CW'(pos_x_q[10:0]);
				ty_q <= ry_w[18] ? CW'(pos_y_q[10:0]) : CW'(ONE_CELL) - CW'(pos_y_q[10:0]);
			end
			ST_CMP: begin
				pa_q <= pb;
			end
			ST_STEP: begin
				if (pa_q < pb) begin
					crossed_q <= tx_q;
					tx_q <= tx_q + CW'(ONE_CELL);
					mx_q <= sx_q ? mx_q - 1'b1 : mx_q + 1'b1;
					side_q <= 1'b0;
				end else begin
					crossed_q <= ty_q;
					ty_q <= ty_q + CW'(ONE_CELL);
					my_q <= sy_q ? my_q - 1'b1 : my_q + 1'b1;
					side_q <= 1'b1;
				end
				steps_q <= steps_q + 1'b1;
			end
			ST_CHECK: begin
				code_q <= ram_rdata;
				hit_q <= ram_rdata != 4'd0;
			end
			ST_DIV: begin
				if (div_done) begin
					if (crossed_q == '0 || div_quo > NW'(2 * SCREEN_HEIGHT))
						h_q <= HW'(2 * SCREEN_HEIGHT);
					else h_q <= HW'(div_quo);
				end
			end
			default: ;
		endcase
	end

	logic [HW-1:0] half_h;
	logic signed [HW+1:0] ds, de;
	assign half_h = h_q >> 1;
	assign ds = (HW + 2)'(SCREEN_HEIGHT / 2) - (HW + 2)'(half_h);
	assign de = (HW + 2)'(SCREEN_HEIGHT / 2) + (HW + 2)'(half_h);

	logic [9:0]  ds_c, de_c;
	logic [23:0] color;
	always_comb begin
		ds_c = ds < 0 ? 10'd0 : 10'(ds);
		if (de >= (HW + 2)'(SCREEN_HEIGHT)) de_c = 10'(SCREEN_HEIGHT - 1);
		else if (de <= 0) de_c = 10'd1;
		else de_c = 10'(de);
		color = code_color(code_q);
		if (side_q) color = color >> 1;
		if (code_q == CODE_FACE) begin
			if (!side_q) color = sx_q ? 24'hFF0000 : 24'hFFFF00;
			else color = sy_q ? 24'h0000FF : 24'h00FF00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_take) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			column_out <= col_q;
			no_hit <= !hit_q;
			if (hit_q) begin
				draw_start <= ds_c;
				draw_end <= de_c;
				wall_color <= color;
				hit_side <= side_q;
			end else begin
				draw_start <= 10'd0;
				draw_end <= 10'd1;
				wall_color <= 24'd0;
				hit_side <= 1'b0;
			end
		end
	end
endmodule
